// ===== hw/rtl/mqprl_pkg.sv =====
// Shared types and constants for the multi-queue priority ready list.
`timescale 1ns / 1ps
`default_nettype none

package mqprl_pkg;

  localparam int unsigned DefPoolEntries = 16;
  localparam int unsigned DefQueueCount  = 4;
  localparam int unsigned DefIdBits      = 8;

  localparam int unsigned PidW  = 8;
  localparam int unsigned QidxW = 2;
  localparam int unsigned PriW  = 4;
  localparam int unsigned MaskW = 4;

  localparam logic [PriW-1:0]  PrioMax   = 4'd9;
  localparam logic [MaskW-1:0] MaskReset = 4'd5;

  localparam logic ModeInsert = 1'b0;
  localparam logic ModeRemove = 1'b1;

  typedef enum logic [1:0] {
    StOk       = 2'd0,
    StNotFound = 2'd1,
    StPoolFull = 2'd2,
    StDupId    = 2'd3
  } status_e;

  typedef struct packed {
    logic             mode;
    logic [QidxW-1:0] queue_index;
    logic [PidW-1:0]  process_id;
    logic [PriW-1:0]  priority_req;
  } req_t;

  typedef struct packed {
    status_e         status;
    logic            head_valid;
    logic [PidW-1:0] head_id;
  } rsp_t;

  // Write control for the entry pool: full entry or link field only.
  typedef struct packed {
    logic en;
    logic link_only;
  } wr_ctl_t;

endpackage

`default_nettype wire

// ===== hw/rtl/multi_queue_priority_ready_list.sv =====
// Top level: process ready/blocked queues over a shared linked entry pool.
//
// Command in: raise start with req_i; the beat is taken when busy is low.
// busy stays high until the result has been shown. Result out: done_o is high
// for exactly one cycle with rsp_o (status, head valid, head id of the
// addressed queue after the operation); the receiver cannot stall it.
// Configuration: cfg_we_i writes priority_queue_mask from cfg_wdata_i;
// write it only while busy is low.
//
// Steps of each command, in order:
//   insert: duplicate-id and free-entry scan over the pool memory, then a list
//           walk on priority queues, then the write of the new entry and, if
//           needed, of a predecessor's link, one head read and the result cycle.
//   remove: list walk, a head read and the result cycle.
//   queue index past the queue count: result in the cycle after the accept edge.
// The single read port of the pool memory sets the pace: one entry per cycle.
// Reset empties all queues, frees every entry and sets the mask to 5.
`timescale 1ns / 1ps
`default_nettype none

module multi_queue_priority_ready_list #(
  parameter int unsigned POOL_ENTRIES = mqprl_pkg::DefPoolEntries,
  parameter int unsigned QUEUE_COUNT  = mqprl_pkg::DefQueueCount,
  parameter int unsigned ID_BITS      = mqprl_pkg::DefIdBits
) (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  wire                          start,
  output logic                         busy,
  input  mqprl_pkg::req_t              req_i,
  output logic                         done_o,
  output mqprl_pkg::rsp_t              rsp_o,
  input  wire                          cfg_we_i,
  input  wire  [mqprl_pkg::MaskW-1:0]  cfg_wdata_i
);

  localparam int unsigned SW  = $clog2(POOL_ENTRIES);
  localparam int unsigned CW  = $clog2(POOL_ENTRIES + 1);
  localparam int unsigned QW  = (QUEUE_COUNT > 1) ? $clog2(QUEUE_COUNT) : 1;
  localparam int unsigned PW  = mqprl_pkg::PriW;

  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_SCAN     = 3'd1;
  localparam logic [2:0] S_WALK_GO  = 3'd2;
  localparam logic [2:0] S_WALK     = 3'd3;
  localparam logic [2:0] S_INS_NEW  = 3'd4;
  localparam logic [2:0] S_INS_LINK = 3'd5;
  localparam logic [2:0] S_HEAD     = 3'd6;
  localparam logic [2:0] S_OUT      = 3'd7;

  // Control state
  logic [2:0]                  state_q, state_d;
  logic [mqprl_pkg::MaskW-1:0] mask_q;
  logic [POOL_ENTRIES-1:0]     used_q, used_d;
  logic [SW-1:0]               head_q [QUEUE_COUNT];
  logic [SW-1:0]               head_d [QUEUE_COUNT];
  logic [SW-1:0]               tail_q [QUEUE_COUNT];
  logic [SW-1:0]               tail_d [QUEUE_COUNT];
  logic [CW-1:0]               len_q  [QUEUE_COUNT];
  logic [CW-1:0]               len_d  [QUEUE_COUNT];

  // Per-command working registers
  logic                 mode_q, mode_d;
  logic                 bad_q, bad_d;
  logic                 ordered_q, ordered_d;
  logic [QW-1:0]        q_q, q_d;
  logic [ID_BITS-1:0]   id_q, id_d;
  logic [PW-1:0]        pri_q, pri_d;
  mqprl_pkg::status_e   status_q, status_d;
  logic [CW-1:0]        scan_q, scan_d;
  logic                 chk_used_q, chk_used_d;
  logic                 dup_q, dup_d;
  logic                 free_found_q, free_found_d;
  logic [SW-1:0]        free_slot_q, free_slot_d;
  logic [SW-1:0]        cur_q, cur_d;
  logic [SW-1:0]        prev_q, prev_d;
  logic                 has_prev_q, has_prev_d;
  logic [CW-1:0]        n_q, n_d;
  logic [SW-1:0]        new_link_q, new_link_d;
  logic [SW-1:0]        link_addr_q, link_addr_d;
  logic                 head_upd_q, head_upd_d;
  logic                 tail_upd_q, tail_upd_d;
  logic                 link_upd_q, link_upd_d;

  // Pool port signals
  mqprl_pkg::wr_ctl_t   wr_ctl;
  logic [SW-1:0]        wr_addr;
  logic [SW-1:0]        wr_link;
  logic [SW-1:0]        rd_addr;
  logic [ID_BITS-1:0]   rd_id;
  logic [PW-1:0]        rd_pri;
  logic [SW-1:0]        rd_link;

  // Decode helpers
  logic                 q_ok;
  logic [QW-1:0]        q_in;
  logic [QW-1:0]        q_sel;
  logic [ID_BITS-1:0]   id_in;
  logic [SW-1:0]        scan_idx;
  logic                 scan_hit;
  logic                 in_range;
  logic                 head_valid;

  assign q_ok     = int'(req_i.queue_index) < QUEUE_COUNT;
  assign q_in     = QW'(req_i.queue_index);
  assign q_sel    = q_ok ? q_in : '0;
  assign id_in    = ID_BITS'(req_i.process_id);
  assign scan_idx = scan_q[SW-1:0];
  assign scan_hit = (scan_q != '0) && chk_used_q && (rd_id == id_q);
  assign in_range = n_q < len_q[q_q];

  mqprl_pool #(
    .POOL_ENTRIES (POOL_ENTRIES),
    .ID_BITS      (ID_BITS)
  ) u_pool (
    .clk_i     (clk_i),
    .wr_ctl_i  (wr_ctl),
    .wr_addr_i (wr_addr),
    .wr_id_i   (id_q),
    .wr_pri_i  (pri_q),
    .wr_link_i (wr_link),
    .rd_addr_i (rd_addr),
    .rd_id_o   (rd_id),
    .rd_pri_o  (rd_pri),
    .rd_link_o (rd_link)
  );

  always_comb begin
    state_d      = state_q;
    used_d       = used_q;
    head_d       = head_q;
    tail_d       = tail_q;
    len_d        = len_q;
    mode_d       = mode_q;
    bad_d        = bad_q;
    ordered_d    = ordered_q;
    q_d          = q_q;
    id_d         = id_q;
    pri_d        = pri_q;
    status_d     = status_q;
    scan_d       = scan_q;
    chk_used_d   = chk_used_q;
    dup_d        = dup_q;
    free_found_d = free_found_q;
    free_slot_d  = free_slot_q;
    cur_d        = cur_q;
    prev_d       = prev_q;
    has_prev_d   = has_prev_q;
    n_d          = n_q;
    new_link_d   = new_link_q;
    link_addr_d  = link_addr_q;
    head_upd_d   = head_upd_q;
    tail_upd_d   = tail_upd_q;
    link_upd_d   = link_upd_q;
    wr_ctl       = '0;
    wr_addr      = '0;
    wr_link      = '0;
    rd_addr      = '0;

    unique case (state_q)
      S_IDLE: begin
        if (start) begin
          mode_d       = req_i.mode;
          id_d         = id_in;
          pri_d        = (req_i.priority_req > mqprl_pkg::PrioMax) ?
                         mqprl_pkg::PrioMax : req_i.priority_req;
          bad_d        = !q_ok;
          q_d          = q_sel;
          ordered_d    = mask_q[req_i.queue_index];
          scan_d       = '0;
          dup_d        = 1'b0;
          free_found_d = 1'b0;
          n_d          = '0;
          has_prev_d   = 1'b0;
          status_d     = mqprl_pkg::StOk;
          if (!q_ok) begin
            status_d = mqprl_pkg::StNotFound;
            state_d  = S_OUT;
          end else if (req_i.mode == mqprl_pkg::ModeInsert) begin
            state_d = S_SCAN;
          end else if (len_q[q_sel] == '0) begin
            status_d = mqprl_pkg::StNotFound;
            state_d  = S_HEAD;
          end else begin
            state_d = S_WALK_GO;
          end
        end
      end

      S_SCAN: begin
        // Issue one entry read per cycle; check the one read last cycle.
        if (scan_q < CW'(POOL_ENTRIES)) begin
          rd_addr    = scan_idx;
          chk_used_d = used_q[scan_idx];
          scan_d     = scan_q + CW'(1);
          if (!used_q[scan_idx] && !free_found_q) begin
            free_found_d = 1'b1;
            free_slot_d  = scan_idx;
          end
        end
        dup_d = dup_q | scan_hit;
        if (scan_q == CW'(POOL_ENTRIES)) begin
          if (dup_d) begin
            status_d = mqprl_pkg::StDupId;
            state_d  = S_HEAD;
          end else if (!free_found_q) begin
            status_d = mqprl_pkg::StPoolFull;
            state_d  = S_HEAD;
          end else if (len_q[q_q] == '0) begin
            new_link_d = '0;
            head_upd_d = 1'b1;
            tail_upd_d = 1'b1;
            link_upd_d = 1'b0;
            state_d    = S_INS_NEW;
          end else if (!ordered_q) begin
            new_link_d  = '0;
            head_upd_d  = 1'b0;
            tail_upd_d  = 1'b1;
            link_upd_d  = 1'b1;
            link_addr_d = tail_q[q_q];
            state_d     = S_INS_NEW;
          end else begin
            state_d = S_WALK_GO;
          end
        end
      end

      S_WALK_GO: begin
        rd_addr    = head_q[q_q];
        cur_d      = head_q[q_q];
        n_d        = '0;
        has_prev_d = 1'b0;
        state_d    = S_WALK;
      end

      S_WALK: begin
        if (mode_q == mqprl_pkg::ModeInsert) begin
          if (in_range && (rd_pri <= pri_q)) begin
            prev_d     = cur_q;
            has_prev_d = 1'b1;
            cur_d      = rd_link;
            n_d        = n_q + CW'(1);
            rd_addr    = rd_link;
          end else begin
            link_addr_d = prev_q;
            if (in_range) begin
              new_link_d = cur_q;
              head_upd_d = !has_prev_q;
              tail_upd_d = 1'b0;
              link_upd_d = has_prev_q;
            end else begin
              // Walked past the tail: append behind it.
              new_link_d = '0;
              head_upd_d = 1'b0;
              tail_upd_d = 1'b1;
              link_upd_d = 1'b1;
            end
            state_d = S_INS_NEW;
          end
        end else begin
          if (!in_range) begin
            status_d = mqprl_pkg::StNotFound;
            state_d  = S_HEAD;
          end else if (rd_id == id_q) begin
            // Unlink the entry and free it.
            status_d      = mqprl_pkg::StOk;
            used_d[cur_q] = 1'b0;
            len_d[q_q]    = len_q[q_q] - CW'(1);
            if (has_prev_q) begin
              wr_ctl  = '{en: 1'b1, link_only: 1'b1};
              wr_addr = prev_q;
              wr_link = rd_link;
            end
            if (len_q[q_q] == CW'(1)) begin
              head_d[q_q] = '0;
              tail_d[q_q] = '0;
            end else begin
              if (!has_prev_q) begin
                head_d[q_q] = rd_link;
              end
              if (cur_q == tail_q[q_q]) begin
                tail_d[q_q] = prev_q;
              end
            end
            state_d = S_HEAD;
          end else begin
            prev_d     = cur_q;
            has_prev_d = 1'b1;
            cur_d      = rd_link;
            n_d        = n_q + CW'(1);
            rd_addr    = rd_link;
          end
        end
      end

      S_INS_NEW: begin
        wr_ctl              = '{en: 1'b1, link_only: 1'b0};
        wr_addr             = free_slot_q;
        wr_link             = new_link_q;
        used_d[free_slot_q] = 1'b1;
        len_d[q_q]          = len_q[q_q] + CW'(1);
        if (head_upd_q) begin
          head_d[q_q] = free_slot_q;
        end
        if (tail_upd_q) begin
          tail_d[q_q] = free_slot_q;
        end
        state_d = link_upd_q ? S_INS_LINK : S_HEAD;
      end

      S_INS_LINK: begin
        wr_ctl  = '{en: 1'b1, link_only: 1'b1};
        wr_addr = link_addr_q;
        wr_link = free_slot_q;
        state_d = S_HEAD;
      end

      S_HEAD: begin
        rd_addr = head_q[q_q];
        state_d = S_OUT;
      end

      S_OUT: begin
        state_d = S_IDLE;
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      mask_q  <= mqprl_pkg::MaskReset;
      used_q  <= '0;
      for (int i = 0; i < QUEUE_COUNT; i++) begin
        head_q[i] <= '0;
        tail_q[i] <= '0;
        len_q[i]  <= '0;
      end
    end else begin
      state_q <= state_d;
      used_q  <= used_d;
      head_q  <= head_d;
      tail_q  <= tail_d;
      len_q   <= len_d;
      if (cfg_we_i) begin
        mask_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    mode_q       <= mode_d;
    bad_q        <= bad_d;
    ordered_q    <= ordered_d;
    q_q          <= q_d;
    id_q         <= id_d;
    pri_q        <= pri_d;
    status_q     <= status_d;
    scan_q       <= scan_d;
    chk_used_q   <= chk_used_d;
    dup_q        <= dup_d;
    free_found_q <= free_found_d;
    free_slot_q  <= free_slot_d;
    cur_q        <= cur_d;
    prev_q       <= prev_d;
    has_prev_q   <= has_prev_d;
    n_q          <= n_d;
    new_link_q   <= new_link_d;
    link_addr_q  <= link_addr_d;
    head_upd_q   <= head_upd_d;
    tail_upd_q   <= tail_upd_d;
    link_upd_q   <= link_upd_d;
  end

  // Head entry was read in the cycle before the result beat.
  assign head_valid        = !bad_q && (len_q[q_q] != '0);
  assign busy              = state_q != S_IDLE;
  assign done_o            = state_q == S_OUT;
  assign rsp_o.status      = status_q;
  assign rsp_o.head_valid  = head_valid;
  assign rsp_o.head_id     = head_valid ? mqprl_pkg::PidW'(rd_id) : '0;

  a_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> busy)
    else $error("command taken but block not busy");

  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !busy)
    else $error("block still busy after result beat");

  a_slot_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_INS_NEW |-> !used_q[free_slot_q])
    else $error("insert takes an entry already in use");

  a_full_real: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && rsp_o.status == mqprl_pkg::StPoolFull |->
      $countones(used_q) == POOL_ENTRIES)
    else $error("pool full reported with a free entry");

endmodule

`default_nettype wire

// ===== hw/rtl/mqprl_pool.sv =====
// Entry pool memory: id, priority and link per entry, one write and one read port.
`timescale 1ns / 1ps
`default_nettype none

module mqprl_pool #(
  parameter int unsigned POOL_ENTRIES = mqprl_pkg::DefPoolEntries,
  parameter int unsigned ID_BITS      = mqprl_pkg::DefIdBits
) (
  input  wire                            clk_i,
  input  mqprl_pkg::wr_ctl_t             wr_ctl_i,
  input  wire  [$clog2(POOL_ENTRIES)-1:0] wr_addr_i,
  input  wire  [ID_BITS-1:0]             wr_id_i,
  input  wire  [mqprl_pkg::PriW-1:0]     wr_pri_i,
  input  wire  [$clog2(POOL_ENTRIES)-1:0] wr_link_i,
  input  wire  [$clog2(POOL_ENTRIES)-1:0] rd_addr_i,
  output logic [ID_BITS-1:0]             rd_id_o,
  output logic [mqprl_pkg::PriW-1:0]     rd_pri_o,
  output logic [$clog2(POOL_ENTRIES)-1:0] rd_link_o
);

  localparam int unsigned SW = $clog2(POOL_ENTRIES);

  logic [ID_BITS-1:0]         id_mem_q   [POOL_ENTRIES];
  logic [mqprl_pkg::PriW-1:0] pri_mem_q  [POOL_ENTRIES];
  logic [SW-1:0]              link_mem_q [POOL_ENTRIES];

  logic [ID_BITS-1:0]         rd_id_q;
  logic [mqprl_pkg::PriW-1:0] rd_pri_q;
  logic [SW-1:0]              rd_link_q;

  always_ff @(posedge clk_i) begin
    if (wr_ctl_i.en) begin
      link_mem_q[wr_addr_i] <= wr_link_i;
      if (!wr_ctl_i.link_only) begin
        id_mem_q[wr_addr_i]  <= wr_id_i;
        pri_mem_q[wr_addr_i] <= wr_pri_i;
      end
    end
  end

  // Read zero past the pool end when the depth is not a power of two.
  always_ff @(posedge clk_i) begin
    if (int'(rd_addr_i) < POOL_ENTRIES) begin
      rd_id_q   <= id_mem_q[rd_addr_i];
      rd_pri_q  <= pri_mem_q[rd_addr_i];
      rd_link_q <= link_mem_q[rd_addr_i];
    end else begin
      rd_id_q   <= '0;
      rd_pri_q  <= '0;
      rd_link_q <= '0;
    end
  end

  assign rd_id_o   = rd_id_q;
  assign rd_pri_o  = rd_pri_q;
  assign rd_link_o = rd_link_q;

endmodule

`default_nettype wire

// ===== tb/tb.sv =====
// Self-checking testbench for the multi-queue priority ready list.
`timescale 1ns / 1ps

module tb;
  import mqprl_pkg::*;

  localparam int unsigned Pool     = DefPoolEntries;
  localparam int unsigned NumQ     = DefQueueCount;
  localparam int unsigned SlotW    = $clog2(DefPoolEntries);
  localparam int unsigned CycLimit = 300000;
  localparam int unsigned RandPer  = 100;

  typedef struct {
    req_t req;
    bit   typed;
    rsp_t rsp;
  } stim_row_t;

  logic             clk_i;
  logic             rst_ni;
  logic             start;
  logic             busy;
  req_t             req_i;
  logic             done_o;
  rsp_t             rsp_o;
  logic             cfg_we_i;
  logic [MaskW-1:0] cfg_wdata_i;

  // Local copy of the pool and the queue bookkeeping
  logic [PidW-1:0]  slot_pid   [Pool];
  logic [PriW-1:0]  slot_pri   [Pool];
  logic [SlotW-1:0] slot_next  [Pool];
  bit               slot_used  [Pool];
  int               slot_owner [Pool];
  logic [SlotW-1:0] q_head     [NumQ];
  logic [SlotW-1:0] q_tail     [NumQ];
  logic [4:0]       q_len      [NumQ];
  logic [MaskW-1:0] prio_mask;

  rsp_t        pending_rsp_q[$];
  stim_row_t   dir_rows[$];
  rsp_t        want_rsp;
  int          gap_pct;
  int unsigned mismatch_cnt = 0;
  int unsigned cycle_cnt = 0;

  multi_queue_priority_ready_list dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .req_i       (req_i),
    .done_o      (done_o),
    .rsp_o       (rsp_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  function automatic status_e enqueue_pid(int q, logic [PidW-1:0] pid,
                                          logic [PriW-1:0] pri);
    logic [SlotW-1:0] cur, prev, fresh;
    int n;
    bit found, has_prev, append;
    found = 0;
    fresh = '0;
    for (int i = 0; i < Pool; i++) begin
      if (slot_used[i] && slot_pid[i] == pid) return StDupId;
    end
    for (int i = Pool - 1; i >= 0; i--) begin
      if (!slot_used[i]) begin
        fresh = SlotW'(i);
        found = 1;
      end
    end
    if (!found) return StPoolFull;
    if (pri > PrioMax) pri = PrioMax;
    slot_used[fresh]  = 1;
    slot_pid[fresh]   = pid;
    slot_pri[fresh]   = pri;
    slot_next[fresh]  = '0;
    slot_owner[fresh] = q;
    if (q_len[q] == 0) begin
      q_head[q] = fresh;
      q_tail[q] = fresh;
    end else begin
      append = 1;
      if (q < MaskW && prio_mask[q]) begin
        cur      = q_head[q];
        prev     = '0;
        n        = 0;
        has_prev = 0;
        // walk past every entry of equal or better priority
        while (n < q_len[q] && slot_pri[cur] <= pri) begin
          prev     = cur;
          has_prev = 1;
          cur      = slot_next[cur];
          n++;
        end
        if (n < q_len[q]) begin
          append          = 0;
          slot_next[fresh] = cur;
          if (has_prev) slot_next[prev] = fresh;
          else q_head[q] = fresh;
        end
      end
      if (append) begin
        slot_next[q_tail[q]] = fresh;
        q_tail[q]            = fresh;
      end
    end
    q_len[q]++;
    return StOk;
  endfunction

  function automatic status_e dequeue_pid(int q, logic [PidW-1:0] pid);
    logic [SlotW-1:0] cur, prev, nxt;
    bit has_prev;
    cur      = q_head[q];
    prev     = '0;
    has_prev = 0;
    for (int n = 0; n < q_len[q]; n++) begin
      if (slot_pid[cur] == pid) begin
        nxt = slot_next[cur];
        if (has_prev) slot_next[prev] = nxt;
        else q_head[q] = nxt;
        if (cur == q_tail[q]) q_tail[q] = prev;
        q_len[q]--;
        if (q_len[q] == 0) begin
          q_head[q] = '0;
          q_tail[q] = '0;
        end
        slot_used[cur] = 0;
        slot_next[cur] = '0;
        return StOk;
      end
      prev     = cur;
      has_prev = 1;
      cur      = slot_next[cur];
    end
    return StNotFound;
  endfunction

  function automatic rsp_t predict_rsp(req_t r);
    rsp_t o;
    int q;
    o = '0;
    q = r.queue_index;
    if (q >= NumQ) begin
      o.status = StNotFound;
      return o;
    end
    o.status = (r.mode == ModeInsert) ? enqueue_pid(q, r.process_id, r.priority_req)
                                      : dequeue_pid(q, r.process_id);
    if (q_len[q] != 0) begin
      o.head_valid = 1'b1;
      o.head_id    = slot_pid[q_head[q]];
    end
    return o;
  endfunction

  // Small id set keeps duplicates and hits common; removes often aim at live ids.
  function automatic req_t random_req();
    req_t r;
    int live[$];
    int k;
    r.mode         = ($urandom_range(0, 99) < 55) ? ModeInsert : ModeRemove;
    r.queue_index  = QidxW'($urandom_range(0, 3));
    r.priority_req = $urandom_range(0, 1) ? PriW'($urandom_range(0, 3))
                                          : PriW'($urandom_range(0, 15));
    r.process_id   = ($urandom_range(0, 9) < 7) ? PidW'($urandom_range(0, 23))
                                                : PidW'($urandom_range(0, 255));
    if (r.mode == ModeRemove && $urandom_range(0, 1)) begin
      for (int i = 0; i < Pool; i++) begin
        if (slot_used[i]) live.push_back(i);
      end
      if (live.size() > 0) begin
        k = live[$urandom_range(0, live.size() - 1)];
        r.process_id = slot_pid[k];
        if ($urandom_range(0, 4) != 0) r.queue_index = QidxW'(slot_owner[k]);
      end
    end
    return r;
  endfunction

  task automatic add_row(logic mode, int q, int pid, int pri, bit typed,
                         status_e st, bit hv, int hid);
    stim_row_t row;
    row.req.mode         = mode;
    row.req.queue_index  = QidxW'(q);
    row.req.process_id   = PidW'(pid);
    row.req.priority_req = PriW'(pri);
    row.typed            = typed;
    row.rsp.status       = st;
    row.rsp.head_valid   = hv;
    row.rsp.head_id      = PidW'(hid);
    dir_rows.push_back(row);
  endtask

  // Called at a falling edge; returns at the falling edge after acceptance.
  task automatic send_cmd(req_t r, bit typed, rsp_t typed_rsp);
    rsp_t pred;
    while ($urandom_range(0, 99) < gap_pct) begin
      start <= 1'b0;
      @(negedge clk_i);
    end
    start <= 1'b1;
    req_i <= r;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    pred = predict_rsp(r);
    pending_rsp_q.push_back(typed ? typed_rsp : pred);
    @(negedge clk_i);
  endtask

  task automatic drain_and_write_mask(logic [MaskW-1:0] m);
    start <= 1'b0;
    @(negedge clk_i);
    while (pending_rsp_q.size() != 0 || busy) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= m;
    prio_mask    = m;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CycLimit) begin
      $display("Simulation FAILED");
      $finish;
    end else if (rst_ni && done_o) begin
      if (pending_rsp_q.size() == 0) begin
        if (mismatch_cnt < 10)
          $display("%0t: result with nothing pending: status %0d head %0d/%0h",
                   $realtime, rsp_o.status, rsp_o.head_valid, rsp_o.head_id);
        mismatch_cnt++;
      end else begin
        want_rsp = pending_rsp_q.pop_front();
        if (rsp_o.status !== want_rsp.status || rsp_o.head_valid !== want_rsp.head_valid
            || rsp_o.head_id !== want_rsp.head_id) begin
          if (mismatch_cnt < 10)
            $display("%0t: mismatch exp st %0d hv %0d id %0h, got st %0d hv %0d id %0h",
                     $realtime, want_rsp.status, want_rsp.head_valid, want_rsp.head_id,
                     rsp_o.status, rsp_o.head_valid, rsp_o.head_id);
          mismatch_cnt++;
        end
      end
    end
  end

  initial begin
    logic [MaskW-1:0] phase_mask [6];
    rsp_t no_rsp;
    rst_ni       = 1'b0;
    start        = 1'b0;
    req_i        = '0;
    cfg_we_i     = 1'b0;
    cfg_wdata_i  = '0;
    no_rsp       = '0;
    prio_mask    = MaskReset;
    for (int i = 0; i < Pool; i++) begin
      slot_pid[i]   = '0;
      slot_pri[i]   = '0;
      slot_next[i]  = '0;
      slot_used[i]  = 0;
      slot_owner[i] = 0;
    end
    for (int i = 0; i < NumQ; i++) begin
      q_head[i] = '0;
      q_tail[i] = '0;
      q_len[i]  = '0;
    end

    // Fill the pool across all queues, hit all three error codes, then unlink
    add_row(ModeRemove, 0, 8'h05, 0,  1, StNotFound, 0, 8'h00);
    add_row(ModeInsert, 0, 8'h00, 0,  1, StOk,       1, 8'h00);
    add_row(ModeInsert, 0, 8'hFF, 15, 0, StOk,       0, 0);
    add_row(ModeInsert, 0, 8'h10, 9,  0, StOk,       0, 0);
    add_row(ModeInsert, 0, 8'h20, 0,  0, StOk,       0, 0);
    add_row(ModeInsert, 1, 8'hFF, 3,  1, StDupId,    0, 8'h00);
    add_row(ModeInsert, 1, 8'h55, 15, 0, StOk,       0, 0);
    add_row(ModeInsert, 1, 8'hAA, 0,  0, StOk,       0, 0);
    add_row(ModeInsert, 2, 8'h0F, 5,  0, StOk,       0, 0);
    add_row(ModeInsert, 2, 8'hF0, 2,  0, StOk,       0, 0);
    add_row(ModeInsert, 3, 8'h33, 10, 0, StOk,       0, 0);
    for (int i = 1; i <= 7; i++) add_row(ModeInsert, 3, i, 2 * i, 0, StOk, 0, 0);
    add_row(ModeInsert, 3, 8'h80, 1,  1, StPoolFull, 1, 8'h33);
    add_row(ModeInsert, 0, 8'h33, 0,  1, StDupId,    1, 8'h00);
    add_row(ModeRemove, 0, 8'hFF, 0,  0, StOk,       0, 0);
    add_row(ModeRemove, 0, 8'h00, 0,  0, StOk,       0, 0);
    add_row(ModeRemove, 1, 8'hAA, 0,  0, StOk,       0, 0);
    add_row(ModeRemove, 2, 8'h55, 0,  0, StOk,       0, 0);
    add_row(ModeRemove, 3, 8'h07, 0,  0, StOk,       0, 0);

    repeat (2) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    gap_pct = 27;
    foreach (dir_rows[i]) send_cmd(dir_rows[i].req, dir_rows[i].typed, dir_rows[i].rsp);

    phase_mask[0] = 4'hF;
    phase_mask[1] = 4'h0;
    phase_mask[2] = 4'h3;
    phase_mask[3] = 4'hC;
    phase_mask[4] = MaskW'($urandom_range(0, 15));
    phase_mask[5] = MaskW'($urandom_range(0, 15));
    for (int ph = 0; ph < 6; ph++) begin
      drain_and_write_mask(phase_mask[ph]);
      gap_pct = (ph < 2) ? 27 : (ph < 4) ? 76 : 0;
      for (int n = 0; n < RandPer; n++) send_cmd(random_req(), 0, no_rsp);
    end

    start <= 1'b0;
    while (pending_rsp_q.size() != 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
    if (mismatch_cnt == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hw/rtl/mqprl_pkg.sv
hw/rtl/mqprl_pool.sv
hw/rtl/multi_queue_priority_ready_list.sv
tb/tb.sv
